[src/itp_pkg.sv]
// Shared types, constants and decode functions for the infix to postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_PLUS   = 3'd1,
        OP_MINUS  = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_POW    = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        CL_ALNUM,
        CL_LPAREN,
        CL_RPAREN,
        CL_OP,
        CL_IGNORE
    } char_class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_FLUSH,
        ST_END
    } seq_state_t;

    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t code;
    } stack_cmd_t;

    typedef struct packed {
        op_code_t         top;
        logic [CNT_W-1:0] count;
    } stack_status_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       no_char;
        logic       is_final;
        logic       overflow;
    } result_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;

    localparam int TUSER_NO_CHAR  = 0;
    localparam int TUSER_OVERFLOW = 1;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cl;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A)) begin
            cl = CL_ALNUM;
        end else if (c == CH_LPAREN) begin
            cl = CL_LPAREN;
        end else if (c == CH_RPAREN) begin
            cl = CL_RPAREN;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL ||
                     c == CH_DIV || c == CH_POW) begin
            cl = CL_OP;
        end else begin
            cl = CL_IGNORE;
        end
        return cl;
    endfunction

    function automatic op_code_t op_of_char(input logic [7:0] c);
        op_code_t op;
        unique case (c)
            CH_PLUS:  op = OP_PLUS;
            CH_MINUS: op = OP_MINUS;
            CH_MUL:   op = OP_MUL;
            CH_DIV:   op = OP_DIV;
            CH_POW:   op = OP_POW;
            default:  op = OP_LPAREN;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] char_of_op(input op_code_t op);
        logic [7:0] c;
        unique case (op)
            OP_LPAREN: c = CH_LPAREN;
            OP_PLUS:   c = CH_PLUS;
            OP_MINUS:  c = CH_MINUS;
            OP_MUL:    c = CH_MUL;
            OP_DIV:    c = CH_DIV;
            OP_POW:    c = CH_POW;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] prec_of(input op_code_t op);
        logic [1:0] p;
        unique case (op)
            OP_PLUS, OP_MINUS: p = 2'd1;
            OP_MUL, OP_DIV:    p = 2'd2;
            OP_POW:            p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

[src/itp_stack.sv]
// Operator stack held in a synchronous memory, with top-of-stack read-ahead and forwarding.
`timescale 1ns / 1ps

module itp_stack (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  itp_pkg::stack_cmd_t    cmd,
    output itp_pkg::stack_status_t status
);
    import itp_pkg::*;

    op_code_t mem [STACK_DEPTH];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  rd_index;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              wr_en;
    op_code_t          rdata_reg;
    op_code_t          fwd_data_reg;
    logic              fwd_valid_reg;
    logic              fwd_valid_next;

    always_comb begin
        wr_en      = cmd.push && (count_reg != CNT_W'(STACK_DEPTH));
        count_next = count_reg;
        if (wr_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop && (count_reg != '0)) begin
            count_next = count_reg - CNT_W'(1);
        end
        rd_index       = count_next - CNT_W'(1);
        raddr          = rd_index[ADDR_W-1:0];
        waddr          = count_reg[ADDR_W-1:0];
        fwd_valid_next = wr_en && (waddr == raddr);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= cmd.code;
        end
        rdata_reg    <= mem[raddr];
        fwd_data_reg <= cmd.code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    assign status.count = count_reg;
    assign status.top   = fwd_valid_reg ? fwd_data_reg : rdata_reg;

endmodule

[src/itp_seq.sv]
// Sequencer that decodes each character, drives the stack and forms result beats.
`timescale 1ns / 1ps

module itp_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_char,
    input  logic                  in_last,
    output logic                  res_valid,
    input  logic                  res_free,
    output itp_pkg::result_t       res,
    output itp_pkg::stack_cmd_t    cmd,
    input  itp_pkg::stack_status_t status
);
    import itp_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic        ovf_reg, ovf_next;
    logic        hold_v_reg, hold_v_next;
    logic [7:0]  hold_ch_reg, hold_ch_next;
    logic        hold_ovf_reg, hold_ovf_next;

    char_class_t cls;
    op_code_t    in_op;
    logic        empty;
    logic        full;
    logic        top_is_op;
    logic        pop_cond;
    logic        emit_ok;
    logic        emit_req;
    logic [7:0]  emit_ch;
    logic        push_req;
    op_code_t    push_code;
    logic [1:0]  in_prec;
    logic [1:0]  top_prec;

    always_comb begin
        cls       = classify(char_reg);
        in_op     = op_of_char(char_reg);
        empty     = (status.count == '0);
        full      = (status.count == CNT_W'(STACK_DEPTH));
        top_is_op = !empty && (status.top != OP_LPAREN);
        in_prec   = prec_of(in_op);
        top_prec  = prec_of(status.top);
        pop_cond  = (in_op == OP_POW) ? (top_prec > in_prec) : (top_prec >= in_prec);
        emit_ok   = last_reg ? (!hold_v_reg || res_free) : res_free;
    end

    always_comb begin
        state_next    = state_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        ovf_next      = ovf_reg;
        hold_v_next   = hold_v_reg;
        hold_ch_next  = hold_ch_reg;
        hold_ovf_next = hold_ovf_reg;
        in_ready      = 1'b0;
        emit_req      = 1'b0;
        emit_ch       = 8'h00;
        push_req      = 1'b0;
        push_code     = OP_LPAREN;
        cmd           = '{push: 1'b0, pop: 1'b0, code: OP_LPAREN};
        res_valid     = 1'b0;
        res           = '{char_out: 8'h00, no_char: 1'b0, is_final: 1'b0, overflow: ovf_reg};

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    char_next  = in_char;
                    last_next  = in_last;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                unique case (cls)
                    CL_ALNUM: begin
                        if (emit_ok) begin
                            emit_req   = 1'b1;
                            emit_ch    = char_reg;
                            state_next = last_reg ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    CL_LPAREN: begin
                        push_req   = 1'b1;
                        push_code  = OP_LPAREN;
                        state_next = last_reg ? ST_FLUSH : ST_IDLE;
                    end
                    CL_RPAREN: begin
                        if (top_is_op) begin
                            if (emit_ok) begin
                                emit_req = 1'b1;
                                emit_ch  = char_of_op(status.top);
                                cmd.pop  = 1'b1;
                            end
                        end else begin
                            cmd.pop    = !empty;
                            state_next = last_reg ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    CL_OP: begin
                        if (top_is_op && pop_cond) begin
                            if (emit_ok) begin
                                emit_req = 1'b1;
                                emit_ch  = char_of_op(status.top);
                                cmd.pop  = 1'b1;
                            end
                        end else begin
                            push_req   = 1'b1;
                            push_code  = in_op;
                            state_next = last_reg ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = last_reg ? ST_FLUSH : ST_IDLE;
                    end
                endcase
            end
            ST_FLUSH: begin
                if (!empty) begin
                    if (emit_ok) begin
                        emit_req = 1'b1;
                        emit_ch  = char_of_op(status.top);
                        cmd.pop  = 1'b1;
                    end
                end else begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                if (res_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    if (hold_v_reg) begin
                        res = '{char_out: hold_ch_reg, no_char: 1'b0, is_final: 1'b1,
                                overflow: hold_ovf_reg};
                    end else begin
                        res = '{char_out: 8'h00, no_char: 1'b1, is_final: 1'b1,
                                overflow: ovf_reg};
                    end
                    hold_v_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_req) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                cmd.push = 1'b1;
                cmd.code = push_code;
            end
        end

        // On the last item every beat waits in the hold stage until it is known
        // whether another one follows, so that the end mark lands on the right beat.
        if (emit_req) begin
            if (last_reg) begin
                if (hold_v_reg) begin
                    res_valid = 1'b1;
                    res = '{char_out: hold_ch_reg, no_char: 1'b0, is_final: 1'b0,
                            overflow: hold_ovf_reg};
                end
                hold_v_next   = 1'b1;
                hold_ch_next  = emit_ch;
                hold_ovf_next = ovf_reg;
            end else begin
                res_valid = 1'b1;
                res = '{char_out: emit_ch, no_char: 1'b0, is_final: 1'b0, overflow: ovf_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        last_reg     <= last_next;
        hold_ch_reg  <= hold_ch_next;
        hold_ovf_reg <= hold_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovf_reg    <= 1'b0;
            hold_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovf_reg    <= ovf_next;
            hold_v_reg <= hold_v_next;
        end
    end

endmodule

[src/infix_to_postfix_converter_unit.sv]
// Top level of the infix to postfix converter: sequencer, operator stack and output register.
//
//  Channel | Direction | Ports                        | Content
//  s_      | in        | tvalid tready tdata tlast    | tdata: char_in; tlast: is_last
//  m_      | out       | tvalid tready tdata tlast    | tdata: char_out; tlast: is_final;
//          |           | tuser                        | tuser: no_char, overflow
//
// An item is registered in the idle state and handled in the work state, which pops
// its results off the stack. A last item then flushes each remaining stack entry in the
// flush state, sees the stack empty and delivers the end mark in the end state.
// Each pop is one read of the stack memory, which is read one entry ahead with forwarding.
// Reset clears the stack count, the sticky overflow flag and all valid state.
// The output register decouples the sides; a stalled output holds the sequencer only
// when it has a new beat to hand over.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] no_char, [1] overflow
);
    import itp_pkg::*;

    stack_cmd_t    cmd;
    stack_status_t status;
    result_t       res;
    logic          res_valid;
    logic          res_free;
    logic          out_valid_reg, out_valid_next;
    result_t       out_data_reg, out_data_next;

    itp_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res),
        .cmd       (cmd),
        .status    (status)
    );

    itp_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status)
    );

    always_comb begin
        res_free       = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid                = out_valid_reg;
    assign m_tdata                 = out_data_reg.char_out;
    assign m_tlast                 = out_data_reg.is_final;
    assign m_tuser[TUSER_NO_CHAR]  = out_data_reg.no_char;
    assign m_tuser[TUSER_OVERFLOW] = out_data_reg.overflow;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res_free)
        else $error("result beat handed over while the output register is occupied");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.count <= CNT_W'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    a_nochar_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_NO_CHAR]) |-> (m_tlast && (m_tdata == 8'h00)))
        else $error("empty result beat without end mark");

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && cmd.pop))
        else $error("stack push and pop in the same cycle");
`endif

endmodule

[bench/tb.sv]
// Self-checking testbench for the infix to postfix converter with a shunting-yard scoreboard.
`timescale 1ns / 1ps

module tb;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } char_beat_t;

    class postfix_scoreboard;
        op_code_t op_stack[STACK_DEPTH];
        int       stack_fill;
        bit       overflow_flag;
        result_t  pending[$];
        int       inputs_seen;
        int       beats_checked;
        int       finals_checked;
        int       errors;

        function new();
            stack_fill = 0;
            overflow_flag = 1'b0;
            inputs_seen = 0;
            beats_checked = 0;
            finals_checked = 0;
            errors = 0;
        endfunction

        static function bit is_alnum(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z");
        endfunction

        static function bit op_lookup(input logic [7:0] c, output op_code_t code);
            bit hit;
            hit = 1'b1;
            code = OP_LPAREN;
            case (c)
                CH_PLUS:  code = OP_PLUS;
                CH_MINUS: code = OP_MINUS;
                CH_MUL:   code = OP_MUL;
                CH_DIV:   code = OP_DIV;
                CH_POW:   code = OP_POW;
                default:  hit = 1'b0;
            endcase
            return hit;
        endfunction

        static function bit carries_token(logic [7:0] c);
            op_code_t code;
            return is_alnum(c) || c == CH_LPAREN || c == CH_RPAREN || op_lookup(c, code);
        endfunction

        function logic [7:0] op_symbol(op_code_t op);
            case (op)
                OP_PLUS:  return CH_PLUS;
                OP_MINUS: return CH_MINUS;
                OP_MUL:   return CH_MUL;
                OP_DIV:   return CH_DIV;
                OP_POW:   return CH_POW;
                default:  return CH_LPAREN;
            endcase
        endfunction

        function int op_rank(op_code_t op);
            case (op)
                OP_PLUS, OP_MINUS: return 1;
                OP_MUL, OP_DIV:    return 2;
                OP_POW:            return 3;
                default:           return 0;
            endcase
        endfunction

        function void put_char(logic [7:0] c);
            result_t r;
            r.char_out = c;
            r.no_char  = 1'b0;
            r.is_final = 1'b0;
            r.overflow = overflow_flag;
            pending.push_back(r);
        endfunction

        function void pop_to_output();
            stack_fill--;
            put_char(op_symbol(op_stack[stack_fill]));
        endfunction

        function void push_op(op_code_t op);
            if (stack_fill >= STACK_DEPTH) begin
                overflow_flag = 1'b1;
            end else begin
                op_stack[stack_fill] = op;
                stack_fill++;
            end
        endfunction

        function void note_char(logic [7:0] c, logic last);
            op_code_t code;
            op_code_t top;
            int       queued;
            bit       stop;
            result_t  r;
            inputs_seen++;
            queued = pending.size();
            if (is_alnum(c)) begin
                put_char(c);
            end else if (c == CH_LPAREN) begin
                push_op(OP_LPAREN);
            end else if (c == CH_RPAREN) begin
                while (stack_fill > 0 && op_stack[stack_fill-1] != OP_LPAREN)
                    pop_to_output();
                if (stack_fill > 0)
                    stack_fill--;
            end else if (op_lookup(c, code)) begin
                stop = 1'b0;
                while (stack_fill > 0 && !stop) begin
                    top = op_stack[stack_fill-1];
                    if (top != OP_LPAREN && (op_rank(top) > op_rank(code) ||
                        (code != OP_POW && op_rank(top) == op_rank(code))))
                        pop_to_output();
                    else
                        stop = 1'b1;
                end
                push_op(code);
            end
            if (last) begin
                while (stack_fill > 0)
                    pop_to_output();
                if (pending.size() == queued) begin
                    put_char(8'h00);
                    r = pending.pop_back();
                    r.no_char = 1'b1;
                    pending.push_back(r);
                end
                r = pending.pop_back();
                r.is_final = 1'b1;
                pending.push_back(r);
            end
        endfunction

        function void check_beat(logic [7:0] data, logic last, logic [1:0] user);
            result_t want;
            beats_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got char %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data !== want.char_out) begin
                $display("%0t: char_out expected %h got %h", $time, want.char_out, data);
                errors++;
            end
            if (user[TUSER_NO_CHAR] !== want.no_char) begin
                $display("%0t: no_char expected %b got %b", $time, want.no_char,
                         user[TUSER_NO_CHAR]);
                errors++;
            end
            if (last !== want.is_final) begin
                $display("%0t: is_final expected %b got %b", $time, want.is_final, last);
                errors++;
            end
            if (user[TUSER_OVERFLOW] !== want.overflow) begin
                $display("%0t: overflow expected %b got %b", $time, want.overflow,
                         user[TUSER_OVERFLOW]);
                errors++;
            end
            if (want.is_final)
                finals_checked++;
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    postfix_scoreboard sb = new();
    char_beat_t        char_feed[$];
    int                token_count = 0;
    int                cycle_count = 0;

    infix_to_postfix_converter_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles.", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tlast, m_tuser);
    end

    task automatic add_char(logic [7:0] c, logic last);
        char_beat_t b;
        b.ch = c;
        b.last = last;
        char_feed.push_back(b);
        if (postfix_scoreboard::carries_token(c))
            token_count++;
    endtask

    task automatic add_text(string s, bit mark_last);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], mark_last && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 2))
            0:       return "0" + 8'($urandom_range(0, 9));
            1:       return "A" + 8'($urandom_range(0, 25));
            default: return "a" + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    task automatic add_expression();
        logic [7:0] expr[$];
        int         operands;
        int         depth_open;
        operands = $urandom_range(1, 6);
        depth_open = 0;
        for (int i = 0; i < operands; i++) begin
            if (i > 0)
                expr.push_back(pick_operator());
            while (depth_open < 4 && $urandom_range(0, 3) == 0) begin
                expr.push_back(CH_LPAREN);
                depth_open++;
            end
            expr.push_back(pick_operand());
            if ($urandom_range(0, 9) == 0)
                expr.push_back(CH_SPACE);
            while (depth_open > 0 && $urandom_range(0, 2) == 0) begin
                expr.push_back(CH_RPAREN);
                depth_open--;
            end
        end
        while (depth_open > 0 && $urandom_range(0, 4) != 0) begin
            expr.push_back(CH_RPAREN);
            depth_open--;
        end
        if ($urandom_range(0, 11) == 0)
            expr.push_back(CH_RPAREN);
        if ($urandom_range(0, 9) == 0)
            expr.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            expr.push_back(CH_SPACE);
        for (int i = 0; i < expr.size(); i++)
            add_char(expr[i], i == expr.size() - 1);
    endtask

    task automatic send_beat(char_beat_t b);
        s_tvalid <= 1'b1;
        s_tdata  <= b.ch;
        s_tlast  <= b.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(b.ch, b.last);
    endtask

    initial begin
        bit held;
        int mode;
        int span;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && sb.inputs_seen >= 150) begin
                // Long output stall: the block backs up and must hold off its input.
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 120);
            repeat (span) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin
        int burst;
        int gap;
        add_text("(a-b)/c^d^e", 1'b1);
        add_text("x*y+z)", 1'b1);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(CH_SPACE, 1'b1);
        add_text("(9", 1'b1);
        while (char_feed.size() < 340) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end else begin
                add_expression();
            end
        end
        // Overrun the operator stack with open parens, then flush it.
        repeat (STACK_DEPTH + 2) add_char(CH_LPAREN, 1'b0);
        add_char("q", 1'b1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (char_feed.size() > 0) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 16);
            repeat (burst) begin
                if (char_feed.size() > 0)
                    send_beat(char_feed.pop_front());
            end
            gap = $urandom_range(0, 6);
            if (gap > 0 && char_feed.size() > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Fed %0d characters, %0d of them tokens, and checked %0d postfix beats.",
                 sb.inputs_seen, token_count, sb.beats_checked);
        $display("Covered %0d expressions with nesting, stray parens, noise and overflow.",
                 sb.finals_checked);
        if (sb.pending.size() != 0)
            $display("%0d expected beats never arrived.", sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
